@@ design/trb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_pkg
// Shared types, byte codes and register map of the touch report bridge.
// ----------------------------------------------------------------------------
package trb_pkg;

  // default report buffer depth
  localparam int REPORT_BUFFER_DEPTH = 128;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // source of an input beat
  localparam logic SRC_TOUCH = 1'b0;
  localparam logic SRC_HOST  = 1'b1;

  // destination of an output beat
  localparam logic DEST_HOST  = 1'b0;
  localparam logic DEST_TOUCH = 1'b1;

  // framing and command bytes
  localparam logic [7:0] CODE_START       = 8'hFE;
  localparam logic [7:0] CODE_END         = 8'hFF;
  localparam logic [7:0] CODE_HOST_POLL   = 8'h46;
  localparam logic [7:0] CODE_HOST_RESYNC = 8'h37;
  localparam logic [7:0] CODE_STATUS      = 8'hF5;
  localparam logic [7:0] CODE_RESYNC_HDR  = 8'hF4;

  // register reset values
  localparam logic [7:0] RST_SIZE_FIRST  = 8'h77;
  localparam logic [7:0] RST_SIZE_SECOND = 8'h5F;
  localparam logic [7:0] RST_CLEAR_CMD   = 8'h3D;

  // register map
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_SIZE_FIRST  = 2'd0;
  localparam logic [1:0] REG_SIZE_SECOND = 2'd1;
  localparam logic [1:0] REG_CLEAR_CMD   = 2'd2;

  // reply sequence steps
  localparam logic [2:0] STEP_FIRST      = 3'd0;
  localparam logic [2:0] STEP_LAST_REPLY = 3'd3;
  localparam logic [2:0] STEP_LAST_STAT  = 3'd1;
  localparam logic [2:0] STEP_LAST_SYNC  = 3'd4;

  typedef enum logic [1:0] {
    CMD_REPORT,
    CMD_STATUS,
    CMD_RESYNC
  } cmd_kind_t;

  // one queued reply job
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } cmd_t;

  // configuration register values
  typedef struct packed {
    logic [7:0] size_first;
    logic [7:0] size_second;
    logic [7:0] clear_cmd;
  } cfg_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

endpackage

@@ design/trb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_if
// Valid/ready channels of the bridge: received bytes in, reply bytes out.
// ----------------------------------------------------------------------------
interface trb_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface trb_out_if;
  logic       valid;
  logic       ready;
  logic       dest_port;
  logic [7:0] out_byte;
  logic       last_flag;

  modport source (output valid, output dest_port, output out_byte, output last_flag,
                  input ready);
  modport sink   (input valid, input dest_port, input out_byte, input last_flag,
                  output ready);
endinterface

@@ design/trb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_front
// Accepts received bytes, frames touch reports and turns host commands
// into reply jobs for the command queue.
// ----------------------------------------------------------------------------
module trb_front #(
  parameter int DEPTH = trb_pkg::REPORT_BUFFER_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  trb_in_if.sink               in_ch,
  input  trb_pkg::queue_stat_t q_stat,
  output logic                 push,
  output trb_pkg::cmd_t        push_cmd
);

  localparam int CNT_W = $clog2(DEPTH);
  localparam logic [CNT_W:0] DEPTH_C = (CNT_W + 1)'(DEPTH);

  logic             cap_r, cap_nxt;
  logic             ready_r, ready_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [7:0]       byte0_r, byte0_nxt;
  logic [7:0]       byte1_r, byte1_nxt;
  logic [CNT_W:0]   cnt;
  logic             accept;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // framing and command decode
  always_comb begin
    cap_nxt   = cap_r;
    ready_nxt = ready_r;
    byte0_nxt = byte0_r;
    byte1_nxt = byte1_r;
    cnt       = {1'b0, fill_r};
    push      = 1'b0;
    push_cmd  = '{kind: trb_pkg::CMD_STATUS, byte0: byte0_r, byte1: byte1_r};
    if (accept) begin
      if (in_ch.operation == trb_pkg::SRC_TOUCH) begin
        if (cap_r) begin
          // keep the first two bytes of the report
          if (fill_r[CNT_W-1:1] == '0) begin
            if (fill_r[0]) begin
              byte1_nxt = in_ch.data_byte;
            end else begin
              byte0_nxt = in_ch.data_byte;
            end
          end
          cnt = cnt + 1'b1;
          if (in_ch.data_byte == trb_pkg::CODE_END) begin
            ready_nxt = 1'b1;
            cap_nxt   = 1'b0;
          end
        end
        if (in_ch.data_byte == trb_pkg::CODE_START) begin
          cap_nxt   = 1'b1;
          ready_nxt = 1'b0;
          cnt       = '0;
        end
        // buffer overflow aborts the report
        if (cnt >= DEPTH_C) begin
          cnt       = '0;
          cap_nxt   = 1'b0;
          ready_nxt = 1'b0;
        end
      end else begin
        if (in_ch.data_byte == trb_pkg::CODE_HOST_POLL) begin
          push = 1'b1;
          if (ready_r) begin
            push_cmd.kind = trb_pkg::CMD_REPORT;
            ready_nxt     = 1'b0;
            cnt           = '0;
          end
        end else if (in_ch.data_byte == trb_pkg::CODE_HOST_RESYNC) begin
          push          = 1'b1;
          push_cmd.kind = trb_pkg::CMD_RESYNC;
        end
      end
    end
    fill_nxt = cnt[CNT_W-1:0];
  end

  // report state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= 1'b0;
      ready_r <= 1'b0;
      fill_r  <= '0;
      byte0_r <= '0;
      byte1_r <= '0;
    end else begin
      cap_r   <= cap_nxt;
      ready_r <= ready_nxt;
      fill_r  <= fill_nxt;
      byte0_r <= byte0_nxt;
      byte1_r <= byte1_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_cap_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cap_r && ready_r))
    else $error("capturing and report ready both set");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, fill_r} < DEPTH_C)
    else $error("fill count reached buffer depth");

  a_poll_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_cmd.kind == trb_pkg::CMD_REPORT |=> !ready_r && fill_r == '0)
    else $error("taken report not cleared");
`endif

endmodule

@@ design/trb_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_queue
// Short command queue between the front and the reply sequencer.
// ----------------------------------------------------------------------------
module trb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  trb_pkg::cmd_t        push_cmd,
  input  logic                 pop,
  output trb_pkg::cmd_t        head_cmd,
  output trb_pkg::queue_stat_t q_stat
);

  localparam int PTR_W = $clog2(trb_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(trb_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(trb_pkg::QUEUE_DEPTH);

  trb_pkg::cmd_t    slot_r [trb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == DEPTH_C);
  assign q_stat.valid = (count_r != '0);
  assign head_cmd     = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(trb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(trb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("push into full command queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !q_stat.valid))
    else $error("pop from empty command queue");
`endif

endmodule

@@ design/trb_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_back
// Reply sequencer: takes jobs from the queue and sends their bytes one
// beat a cycle, while the output is ready, through an output register.
// ----------------------------------------------------------------------------
module trb_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  trb_pkg::cfg_t        cfg,
  input  trb_pkg::cmd_t        head_cmd,
  input  trb_pkg::queue_stat_t q_stat,
  output logic                 pop,
  trb_out_if.source            out_ch
);

  trb_pkg::cmd_t cmd_r, cmd_nxt;
  logic          active_r, active_nxt;
  logic [2:0]    step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_dest_r, out_last_r;
  logic [7:0]    out_byte_r;
  logic          load;
  logic          at_last;
  logic [2:0]    last_step;
  logic          beat_dest;
  logic [7:0]    beat_byte;
  logic          beat_last;

  // final step of the current job
  always_comb begin
    unique case (cmd_r.kind)
      trb_pkg::CMD_REPORT: last_step = trb_pkg::STEP_LAST_REPLY;
      trb_pkg::CMD_STATUS: last_step = trb_pkg::STEP_LAST_STAT;
      trb_pkg::CMD_RESYNC: last_step = trb_pkg::STEP_LAST_SYNC;
      default:             last_step = trb_pkg::STEP_FIRST;
    endcase
  end

  // byte of the current step
  always_comb begin
    beat_dest = trb_pkg::DEST_HOST;
    beat_byte = trb_pkg::CODE_END;
    beat_last = at_last;
    unique case (cmd_r.kind)
      trb_pkg::CMD_REPORT: begin
        case (step_r)
          3'd0:    beat_byte = trb_pkg::CODE_START;
          3'd1:    beat_byte = cmd_r.byte0;
          3'd2:    beat_byte = cmd_r.byte1;
          default: beat_byte = trb_pkg::CODE_END;
        endcase
      end
      trb_pkg::CMD_STATUS: begin
        beat_byte = (step_r == trb_pkg::STEP_FIRST) ? trb_pkg::CODE_STATUS
                                                    : trb_pkg::CODE_END;
      end
      trb_pkg::CMD_RESYNC: begin
        case (step_r)
          3'd0: begin
            beat_dest = trb_pkg::DEST_TOUCH;
            beat_byte = cfg.clear_cmd;
            beat_last = 1'b1;
          end
          3'd1:    beat_byte = trb_pkg::CODE_RESYNC_HDR;
          3'd2:    beat_byte = cfg.size_first;
          3'd3:    beat_byte = cfg.size_second;
          default: beat_byte = trb_pkg::CODE_END;
        endcase
      end
      default: beat_byte = trb_pkg::CODE_END;
    endcase
  end

  assign at_last = (step_r == last_step);
  assign load    = active_r && (!out_valid_r || out_ch.ready);
  assign pop     = q_stat.valid && (!active_r || (load && at_last));

  // sequencer control
  always_comb begin
    cmd_nxt    = cmd_r;
    active_nxt = active_r;
    step_nxt   = step_r;
    if (load) begin
      step_nxt = step_r + 1'b1;
      if (at_last) begin
        active_nxt = 1'b0;
      end
    end
    if (pop) begin
      cmd_nxt    = head_cmd;
      active_nxt = 1'b1;
      step_nxt   = trb_pkg::STEP_FIRST;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      step_r      <= trb_pkg::STEP_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // job and output beat payload
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (load) begin
      out_dest_r <= beat_dest;
      out_byte_r <= beat_byte;
      out_last_r <= beat_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.dest_port = out_dest_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_flag = out_last_r;

`ifndef NO_ASSERTIONS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> step_r <= last_step)
    else $error("reply step beyond end of job");

  a_host_end: assert property (@(posedge clk) disable iff (!rst_n)
    load && at_last |=> out_ch.last_flag && out_ch.out_byte == trb_pkg::CODE_END)
    else $error("job did not close with end byte");
`endif

endmodule

@@ design/touch_report_bridge_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_report_bridge_top
// Byte bridge between a touch controller link and a host link, with a
// small register port for the resync reply codes.
// ----------------------------------------------------------------------------
// Path: a host command beat passes the command queue and reply sequencer
// into the output register; touch beats give no output. Throughput: one input
// beat per cycle while the command queue has room; replies go out one beat
// per cycle while the output is ready: 2 or 4 for a poll, 5 for a resync.
// Reset: synchronous rst_n clears report state, the queue and the output
// register, and loads the register defaults; no clearing pass.
module touch_report_bridge_top #(
  parameter int REPORT_BUFFER_DEPTH = trb_pkg::REPORT_BUFFER_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  trb_in_if.sink                        in_ch,
  trb_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  trb_pkg::cfg_t        cfg_r;
  trb_pkg::queue_stat_t q_stat;
  trb_pkg::cmd_t        push_cmd;
  trb_pkg::cmd_t        head_cmd;
  logic                 push;
  logic                 pop;
  logic                 wr_en;
  logic [1:0]           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_first  <= trb_pkg::RST_SIZE_FIRST;
      cfg_r.size_second <= trb_pkg::RST_SIZE_SECOND;
      cfg_r.clear_cmd   <= trb_pkg::RST_CLEAR_CMD;
    end else if (wr_en) begin
      unique case (reg_idx)
        trb_pkg::REG_SIZE_FIRST:  cfg_r.size_first  <= pwdata[7:0];
        trb_pkg::REG_SIZE_SECOND: cfg_r.size_second <= pwdata[7:0];
        trb_pkg::REG_CLEAR_CMD:   cfg_r.clear_cmd   <= pwdata[7:0];
        default:                  cfg_r             <= cfg_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      trb_pkg::REG_SIZE_FIRST:  prdata = {24'd0, cfg_r.size_first};
      trb_pkg::REG_SIZE_SECOND: prdata = {24'd0, cfg_r.size_second};
      trb_pkg::REG_CLEAR_CMD:   prdata = {24'd0, cfg_r.clear_cmd};
      default:                  prdata = 32'd0;
    endcase
  end

  trb_front #(
    .DEPTH (REPORT_BUFFER_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  trb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  trb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head_cmd (head_cmd),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

@@ test/touch_report_bridge_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_report_bridge_top_tb
// Self-checking bench for the touch report bridge. Touch and host bytes go in
// through the input channel, and a predictor of report framing, poll and
// resync replies builds the expected reply beats. Each reply beat is checked
// in order against them. Runs under several register settings and idle mixes,
// including a long output hold-off and a buffer overflow report.
// ----------------------------------------------------------------------------
module touch_report_bridge_top_tb;

  localparam int BUF_DEPTH = trb_pkg::REPORT_BUFFER_DEPTH;

  // one expected reply beat
  typedef struct packed {
    logic       dest;
    logic [7:0] data;
    logic       last;
  } reply_beat_t;

  // predictor of the bridge replies plus the queue of beats still due
  class bridge_reply_model;
    reply_beat_t replies_due[$];
    logic        capturing;
    logic        report_ready;
    logic [7:0]  fill_count;
    logic [7:0]  report_bytes[2];
    logic [7:0]  size_first;
    logic [7:0]  size_second;
    logic [7:0]  clear_cmd;
    int          errors;

    function new();
      capturing    = 1'b0;
      report_ready = 1'b0;
      fill_count   = 8'd0;
      report_bytes[0] = 8'd0;
      report_bytes[1] = 8'd0;
      size_first  = trb_pkg::RST_SIZE_FIRST;
      size_second = trb_pkg::RST_SIZE_SECOND;
      clear_cmd   = trb_pkg::RST_CLEAR_CMD;
      errors      = 0;
    endfunction

    function void set_register(input logic [1:0] idx, input logic [7:0] v);
      case (idx)
        trb_pkg::REG_SIZE_FIRST:  size_first = v;
        trb_pkg::REG_SIZE_SECOND: size_second = v;
        trb_pkg::REG_CLEAR_CMD:   clear_cmd = v;
        default: ;
      endcase
    endfunction

    function void push_reply(input logic dest, input logic [7:0] data, input logic last);
      reply_beat_t beat;
      beat.dest = dest;
      beat.data = data;
      beat.last = last;
      replies_due.push_back(beat);
    endfunction

    // update framing state and queue the replies one input beat causes
    function void take_input_beat(input logic op, input logic [7:0] b);
      int cnt;
      if (op == trb_pkg::SRC_TOUCH) begin
        cnt = fill_count;
        if (capturing) begin
          if (cnt < 2) report_bytes[cnt] = b;
          cnt++;
          if (b == trb_pkg::CODE_END) begin
            report_ready = 1'b1;
            capturing    = 1'b0;
          end
        end
        // start code restarts capture, even mid report
        if (b == trb_pkg::CODE_START) begin
          capturing    = 1'b1;
          report_ready = 1'b0;
          cnt          = 0;
        end
        // buffer overflow aborts everything
        if (cnt > BUF_DEPTH - 1) begin
          cnt          = 0;
          capturing    = 1'b0;
          report_ready = 1'b0;
        end
        fill_count = cnt[7:0];
      end else if (b == trb_pkg::CODE_HOST_POLL) begin
        if (report_ready) begin
          push_reply(trb_pkg::DEST_HOST, trb_pkg::CODE_START, 1'b0);
          push_reply(trb_pkg::DEST_HOST, report_bytes[0], 1'b0);
          push_reply(trb_pkg::DEST_HOST, report_bytes[1], 1'b0);
          push_reply(trb_pkg::DEST_HOST, trb_pkg::CODE_END, 1'b1);
          fill_count   = 8'd0;
          report_ready = 1'b0;
        end else begin
          push_reply(trb_pkg::DEST_HOST, trb_pkg::CODE_STATUS, 1'b0);
          push_reply(trb_pkg::DEST_HOST, trb_pkg::CODE_END, 1'b1);
        end
      end else if (b == trb_pkg::CODE_HOST_RESYNC) begin
        push_reply(trb_pkg::DEST_TOUCH, clear_cmd, 1'b1);
        push_reply(trb_pkg::DEST_HOST, trb_pkg::CODE_RESYNC_HDR, 1'b0);
        push_reply(trb_pkg::DEST_HOST, size_first, 1'b0);
        push_reply(trb_pkg::DEST_HOST, size_second, 1'b0);
        push_reply(trb_pkg::DEST_HOST, trb_pkg::CODE_END, 1'b1);
      end
    endfunction

    // compare one accepted reply beat with the oldest one due
    function void check_reply_beat(input logic dest, input logic [7:0] data,
                                   input logic last);
      reply_beat_t due;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply beat, expected none, actual dest=%0d byte=%02h last=%0d",
                 $time, dest, data, last);
        errors++;
      end else begin
        due = replies_due.pop_front();
        if (due.dest !== dest || due.data !== data || due.last !== last) begin
          $display("%0t: reply mismatch, expected dest=%0d byte=%02h last=%0d,",
                   $time, due.dest, due.data, due.last);
          $display("    actual dest=%0d byte=%02h last=%0d", dest, data, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [trb_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  trb_in_if  in_ch();
  trb_out_if out_ch();

  bridge_reply_model model;

  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int items_sent;

  touch_report_bridge_top #(
    .REPORT_BUFFER_DEPTH(BUF_DEPTH)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("touch_report_bridge_top regression: fail");
    $finish;
  end

  // reply side: check at the rising edge, pick ready at the falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        model.check_reply_beat(out_ch.dest_port, out_ch.out_byte, out_ch.last_flag);
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one byte, with random idle cycles first; starts and ends at a falling edge
  task send_byte(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.data_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    model.take_input_beat(op, b);
    items_sent++;
    @(negedge clk);
  endtask

  // register write: setup phase, then access phase
  task write_register(input logic [1:0] idx, input logic [7:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'd0, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    model.set_register(idx, v);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // stop offering and wait for every due reply, then a short settle
  task wait_for_replies(input int limit_cycles);
    int waited;
    waited = 0;
    in_ch.valid = 1'b0;
    while (model.replies_due.size() != 0 && waited < limit_cycles) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
  endtask

  // random content byte that is neither start nor end code
  function automatic logic [7:0] plain_byte();
    return 8'($urandom_range(253));
  endfunction

  // long report to probe the buffer limit
  task long_report(input int content_len, input bit close_it);
    send_byte(trb_pkg::SRC_TOUCH, trb_pkg::CODE_START);
    for (int i = 0; i < content_len; i++) send_byte(trb_pkg::SRC_TOUCH, plain_byte());
    if (close_it) send_byte(trb_pkg::SRC_TOUCH, trb_pkg::CODE_END);
    send_byte(trb_pkg::SRC_HOST, trb_pkg::CODE_HOST_POLL);
  endtask

  // mostly framed reports and host commands, some noise and broken frames
  task random_traffic(input int item_goal);
    int stop_at;
    int pick;
    int n;
    logic [7:0] b;
    stop_at = items_sent + item_goal;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_byte(trb_pkg::SRC_TOUCH, trb_pkg::CODE_START);
        n = $urandom_range(4);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(255));
          if ($urandom_range(99) < 85) b = plain_byte();
          send_byte(trb_pkg::SRC_TOUCH, b);
        end
        if ($urandom_range(99) < 90) send_byte(trb_pkg::SRC_TOUCH, trb_pkg::CODE_END);
        if ($urandom_range(99) < 75) send_byte(trb_pkg::SRC_HOST, trb_pkg::CODE_HOST_POLL);
      end else if (pick < 60) begin
        send_byte(trb_pkg::SRC_HOST, trb_pkg::CODE_HOST_POLL);
      end else if (pick < 72) begin
        send_byte(trb_pkg::SRC_HOST, trb_pkg::CODE_HOST_RESYNC);
      end else if (pick < 86) begin
        send_byte(trb_pkg::SRC_HOST, 8'($urandom_range(255)));
      end else begin
        send_byte(trb_pkg::SRC_TOUCH, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    model = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = trb_pkg::SRC_TOUCH;
    in_ch.data_byte = 8'd0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = 32'd0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    items_sent    = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: register defaults, no idling
    send_byte(trb_pkg::SRC_HOST, trb_pkg::CODE_HOST_POLL);
    send_byte(trb_pkg::SRC_TOUCH, 8'h12);
    send_byte(trb_pkg::SRC_HOST, 8'h00);
    // end code as first report byte
    send_byte(trb_pkg::SRC_TOUCH, trb_pkg::CODE_START);
    send_byte(trb_pkg::SRC_TOUCH, trb_pkg::CODE_END);
    send_byte(trb_pkg::SRC_HOST, trb_pkg::CODE_HOST_POLL);
    // longer report keeps only two bytes, second poll finds nothing
    send_byte(trb_pkg::SRC_TOUCH, trb_pkg::CODE_START);
    send_byte(trb_pkg::SRC_TOUCH, 8'h5A);
    send_byte(trb_pkg::SRC_TOUCH, 8'hC3);
    send_byte(trb_pkg::SRC_TOUCH, 8'h11);
    send_byte(trb_pkg::SRC_TOUCH, trb_pkg::CODE_END);
    send_byte(trb_pkg::SRC_HOST, trb_pkg::CODE_HOST_POLL);
    send_byte(trb_pkg::SRC_HOST, trb_pkg::CODE_HOST_POLL);
    // restart mid capture, end code as second byte
    send_byte(trb_pkg::SRC_TOUCH, trb_pkg::CODE_START);
    send_byte(trb_pkg::SRC_TOUCH, 8'h01);
    send_byte(trb_pkg::SRC_TOUCH, trb_pkg::CODE_START);
    send_byte(trb_pkg::SRC_TOUCH, 8'h22);
    send_byte(trb_pkg::SRC_TOUCH, trb_pkg::CODE_END);
    send_byte(trb_pkg::SRC_HOST, trb_pkg::CODE_HOST_POLL);
    // start code drops a ready report
    send_byte(trb_pkg::SRC_TOUCH, trb_pkg::CODE_START);
    send_byte(trb_pkg::SRC_TOUCH, 8'h44);
    send_byte(trb_pkg::SRC_TOUCH, trb_pkg::CODE_END);
    send_byte(trb_pkg::SRC_TOUCH, trb_pkg::CODE_START);
    send_byte(trb_pkg::SRC_HOST, trb_pkg::CODE_HOST_POLL);
    send_byte(trb_pkg::SRC_HOST, trb_pkg::CODE_HOST_RESYNC);

    // random phases, each under its own register setting and idle mix
    for (int ph = 0; ph < 4; ph++) begin
      wait_for_replies(20000);
      case (ph)
        0: begin
          write_register(trb_pkg::REG_SIZE_FIRST, 8'h00);
          write_register(trb_pkg::REG_SIZE_SECOND, 8'h00);
          write_register(trb_pkg::REG_CLEAR_CMD, 8'h00);
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          write_register(trb_pkg::REG_SIZE_FIRST, 8'hFF);
          write_register(trb_pkg::REG_SIZE_SECOND, 8'hFF);
          write_register(trb_pkg::REG_CLEAR_CMD, 8'hFF);
          send_idle_pct = 85;
          stall_pct     = 0;
        end
        default: begin
          write_register(trb_pkg::REG_SIZE_FIRST, 8'($urandom_range(255)));
          write_register(trb_pkg::REG_SIZE_SECOND, 8'($urandom_range(255)));
          write_register(trb_pkg::REG_CLEAR_CMD, 8'($urandom_range(255)));
          send_idle_pct = (ph == 2) ? 0 : 28;
          stall_pct     = (ph == 2) ? 85 : 28;
        end
      endcase
      // long output hold-off while input keeps coming
      if (ph == 0 || ph == 2) hold_left = 90;
      // polls back to back fill the queue behind the hold-off
      if (ph == 0) repeat (4) send_byte(trb_pkg::SRC_HOST, trb_pkg::CODE_HOST_POLL);
      random_traffic(4);
      // buffer limit: overflow on the end code drops the report
      if (ph == 3) long_report(BUF_DEPTH - 1, 1'b1);
    end

    // drain and report
    wait_for_replies(20000);
    if (model.replies_due.size() != 0) begin
      $display("%0t: %0d reply beats left over, expected dest=%0d byte=%02h last=%0d,",
               $time, model.replies_due.size(), model.replies_due[0].dest,
               model.replies_due[0].data, model.replies_due[0].last);
      $display("    actual none");
      model.errors++;
    end
    if (model.errors == 0)
      $display("touch_report_bridge_top regression: pass");
    else
      $display("touch_report_bridge_top regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
design/trb_pkg.sv
design/trb_if.sv
design/trb_front.sv
design/trb_queue.sv
design/trb_back.sv
design/touch_report_bridge_top.sv
test/touch_report_bridge_top_tb.sv
